[sv/ctf_pkg.sv]
package ctf_pkg;

   // Field and register widths
   localparam int TYPE_BITS     = 8;
   localparam int LEN_BITS      = 28;
   localparam int THR_BITS      = 32;
   localparam int COUNT_BITS    = 31;
   localparam int CSR_IDX_BITS  = 3;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 8;

   // Saturating add width, insert plus delete width, signed compare width
   localparam int SUM_BITS = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 1;
   localparam int IND_BITS = COUNT_BITS + 1;
   localparam int CMP_BITS = ((IND_BITS > THR_BITS) ? IND_BITS : THR_BITS) + 1;

   // Operation queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;

   typedef enum logic [2:0] {
      OP_CLS_NONE,
      OP_CLS_MATCH,
      OP_CLS_INSERT,
      OP_CLS_DELETE,
      OP_CLS_SOFTCLIP
   } op_class_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MATCH_THR     = 3'd0,
      CSR_INSERT_THR    = 3'd1,
      CSR_DELETE_THR    = 3'd2,
      CSR_INDEL_THR     = 3'd3,
      CSR_SOFTCLIP_THR  = 3'd4,
      CSR_REVERSE       = 3'd5,
      CSR_KEEP_UNMAPPED = 3'd6
   } csr_index_type;

   // One classified operation as it sits in the queue
   typedef struct packed {
      op_class_type          op_class;
      logic [LEN_BITS-1:0]   op_length;
      logic                  record_mapped;
      logic                  last_op;
   } op_entry_type;

   // Filter settings seen by the back end
   typedef struct packed {
      logic signed [THR_BITS-1:0] match_thr;
      logic signed [THR_BITS-1:0] insert_thr;
      logic signed [THR_BITS-1:0] delete_thr;
      logic signed [THR_BITS-1:0] indel_thr;
      logic signed [THR_BITS-1:0] softclip_thr;
      logic                       reverse_mode;
      logic                       keep_unmapped_mode;
   } ctf_cfg_type;

endpackage

[sv/ctf_front.sv]
module ctf_front (
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // op_type [7:0], op_length [35:8], record_mapped [36], zero [39:37]
   input  logic [ctf_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // op_present [0]
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   input  logic                                queue_full,
   output logic                                push,
   output ctf_pkg::op_entry_type               push_entry
);

   localparam logic [ctf_pkg::TYPE_BITS-1:0] CHAR_M = 8'h4D;
   localparam logic [ctf_pkg::TYPE_BITS-1:0] CHAR_I = 8'h49;
   localparam logic [ctf_pkg::TYPE_BITS-1:0] CHAR_D = 8'h44;
   localparam logic [ctf_pkg::TYPE_BITS-1:0] CHAR_S = 8'h53;

   logic [ctf_pkg::TYPE_BITS-1:0] op_type;
   ctf_pkg::op_class_type         op_class;

   assign op_type = req_tdata[ctf_pkg::TYPE_BITS-1:0];

   // Classify the operation character; absent operations count as nothing
   always_comb begin
      op_class = ctf_pkg::OP_CLS_NONE;
      if (req_tuser) begin
         case (op_type)
            CHAR_M:  op_class = ctf_pkg::OP_CLS_MATCH;
            CHAR_I:  op_class = ctf_pkg::OP_CLS_INSERT;
            CHAR_D:  op_class = ctf_pkg::OP_CLS_DELETE;
            CHAR_S:  op_class = ctf_pkg::OP_CLS_SOFTCLIP;
            default: op_class = ctf_pkg::OP_CLS_NONE;
         endcase
      end
   end

   // Items that neither count nor end a record are dropped here
   assign req_tready = !queue_full;
   assign push = req_tvalid && !queue_full &&
                 ((op_class != ctf_pkg::OP_CLS_NONE) || req_tlast);

   assign push_entry.op_class      = op_class;
   assign push_entry.op_length     =
      req_tdata[ctf_pkg::TYPE_BITS +: ctf_pkg::LEN_BITS];
   assign push_entry.record_mapped =
      req_tdata[ctf_pkg::TYPE_BITS + ctf_pkg::LEN_BITS];
   assign push_entry.last_op       = req_tlast;

endmodule

[sv/ctf_queue.sv]
module ctf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ctf_pkg::op_entry_type push_entry,
   input  logic                  pop,
   output ctf_pkg::op_entry_type pop_entry,
   output logic                  not_empty,
   output logic                  full
);

   ctf_pkg::op_entry_type            entry_ff [ctf_pkg::QUEUE_DEPTH];
   logic [ctf_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ctf_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ctf_pkg::QPTR_BITS:0]      count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == (ctf_pkg::QPTR_BITS+1)'(ctf_pkg::QUEUE_DEPTH));
   assign pop_entry = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (ctf_pkg::QPTR_BITS+1)'(ctf_pkg::QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

endmodule

[sv/ctf_back.sv]
module ctf_back (
   input  logic                                clock,
   input  logic                                reset,
   input  ctf_pkg::ctf_cfg_type                cfg,
   input  logic                                q_valid,
   input  ctf_pkg::op_entry_type               q_entry,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // keep_record [0], zero [7:1]
   output logic [ctf_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   localparam logic [ctf_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic signed [ctf_pkg::THR_BITS-1:0] THR_OFF = '1;

   // Saturating add of one length onto a counter
   function automatic logic [ctf_pkg::COUNT_BITS-1:0] sat_add(
      input logic [ctf_pkg::COUNT_BITS-1:0] acc,
      input logic [ctf_pkg::LEN_BITS-1:0]   len
   );
      logic [ctf_pkg::SUM_BITS-1:0] s;
      s = ctf_pkg::SUM_BITS'(acc) + ctf_pkg::SUM_BITS'(len);
      if (s > ctf_pkg::SUM_BITS'(COUNT_MAX)) begin
         return COUNT_MAX;
      end
      return s[ctf_pkg::COUNT_BITS-1:0];
   endfunction

   // Signed threshold test; all ones disables
   function automatic logic passes(
      input logic signed [ctf_pkg::THR_BITS-1:0] thr,
      input logic [ctf_pkg::IND_BITS-1:0]        count,
      input logic                                reverse
   );
      logic signed [ctf_pkg::CMP_BITS-1:0] t;
      logic signed [ctf_pkg::CMP_BITS-1:0] c;
      t = ctf_pkg::CMP_BITS'(thr);
      c = $signed(ctf_pkg::CMP_BITS'(count));
      if (thr == THR_OFF) begin
         return 1'b0;
      end
      return reverse ? (t >= c) : (t <= c);
   endfunction

   logic [ctf_pkg::COUNT_BITS-1:0] match_sum_ff, match_sum_in;
   logic [ctf_pkg::COUNT_BITS-1:0] insert_sum_ff, insert_sum_in;
   logic [ctf_pkg::COUNT_BITS-1:0] delete_sum_ff, delete_sum_in;
   logic [ctf_pkg::COUNT_BITS-1:0] softclip_sum_ff, softclip_sum_in;
   logic [ctf_pkg::COUNT_BITS-1:0] match_next, insert_next, delete_next, softclip_next;

   logic [ctf_pkg::COUNT_BITS-1:0] snap_match_ff, snap_insert_ff;
   logic [ctf_pkg::COUNT_BITS-1:0] snap_delete_ff, snap_softclip_ff;
   logic                           snap_mapped_ff;
   logic                           dec_valid_ff, dec_valid_in;

   logic                           out_valid_ff, out_valid_in;
   logic                           out_keep_ff;

   logic                           out_ready;
   logic                           dec_ready;
   logic                           close_record;
   logic [ctf_pkg::IND_BITS-1:0]   indel_count;
   logic                           keep;

   assign out_ready    = !out_valid_ff || rsp_tready;
   assign dec_ready    = !dec_valid_ff || out_ready;
   assign q_pop        = q_valid && (!q_entry.last_op || dec_ready);
   assign close_record = q_pop && q_entry.last_op;

   // Counter stage: add the popped length to its counter; clear all counters when a record's last operation pops
   always_comb begin
      match_next    = match_sum_ff;
      insert_next   = insert_sum_ff;
      delete_next   = delete_sum_ff;
      softclip_next = softclip_sum_ff;
      case (q_entry.op_class)
         ctf_pkg::OP_CLS_MATCH:    match_next    = sat_add(match_sum_ff, q_entry.op_length);
         ctf_pkg::OP_CLS_INSERT:   insert_next   = sat_add(insert_sum_ff, q_entry.op_length);
         ctf_pkg::OP_CLS_DELETE:   delete_next   = sat_add(delete_sum_ff, q_entry.op_length);
         ctf_pkg::OP_CLS_SOFTCLIP: softclip_next = sat_add(softclip_sum_ff, q_entry.op_length);
         default: ;
      endcase

      match_sum_in    = match_sum_ff;
      insert_sum_in   = insert_sum_ff;
      delete_sum_in   = delete_sum_ff;
      softclip_sum_in = softclip_sum_ff;
      if (close_record) begin
         match_sum_in    = '0;
         insert_sum_in   = '0;
         delete_sum_in   = '0;
         softclip_sum_in = '0;
      end else if (q_pop) begin
         match_sum_in    = match_next;
         insert_sum_in   = insert_next;
         delete_sum_in   = delete_next;
         softclip_sum_in = softclip_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_sum_ff    <= '0;
         insert_sum_ff   <= '0;
         delete_sum_ff   <= '0;
         softclip_sum_ff <= '0;
      end else begin
         match_sum_ff    <= match_sum_in;
         insert_sum_ff   <= insert_sum_in;
         delete_sum_ff   <= delete_sum_in;
         softclip_sum_ff <= softclip_sum_in;
      end
   end

   // Snapshot of final counts, held until the decision moves on
   assign dec_valid_in = close_record ? 1'b1 : (out_ready ? 1'b0 : dec_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else begin
         dec_valid_ff <= dec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (close_record) begin
         snap_match_ff    <= match_next;
         snap_insert_ff   <= insert_next;
         snap_delete_ff   <= delete_next;
         snap_softclip_ff <= softclip_next;
         snap_mapped_ff   <= q_entry.record_mapped;
      end
   end

   // Decision stage: compare snapshot against thresholds
   assign indel_count = ctf_pkg::IND_BITS'(snap_insert_ff) +
                        ctf_pkg::IND_BITS'(snap_delete_ff);

   always_comb begin
      if (cfg.keep_unmapped_mode && !snap_mapped_ff) begin
         keep = 1'b1;
      end else begin
         keep = passes(cfg.match_thr, ctf_pkg::IND_BITS'(snap_match_ff), cfg.reverse_mode)
             || passes(cfg.insert_thr, ctf_pkg::IND_BITS'(snap_insert_ff), cfg.reverse_mode)
             || passes(cfg.delete_thr, ctf_pkg::IND_BITS'(snap_delete_ff), cfg.reverse_mode)
             || passes(cfg.indel_thr, indel_count, cfg.reverse_mode)
             || passes(cfg.softclip_thr, ctf_pkg::IND_BITS'(snap_softclip_ff),
                       cfg.reverse_mode);
      end
   end

   // Output register
   assign out_valid_in = (dec_valid_ff && out_ready) ? 1'b1 :
                         (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_valid_ff && out_ready) begin
         out_keep_ff <= keep;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = ctf_pkg::RSP_DATA_BITS'(out_keep_ff);

   a_counters_clear: assert property (@(posedge clock) disable iff (reset)
      close_record |=> (match_sum_ff == '0) && (insert_sum_ff == '0) &&
                       (delete_sum_ff == '0) && (softclip_sum_ff == '0))
      else $error("counters not cleared after record end");

   a_snapshot_held: assert property (@(posedge clock) disable iff (reset)
      dec_valid_ff && !out_ready |=> dec_valid_ff && $stable(snap_match_ff) &&
                                     $stable(snap_insert_ff) && $stable(snap_delete_ff) &&
                                     $stable(snap_softclip_ff) && $stable(snap_mapped_ff))
      else $error("pending decision lost while output stalled");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(dec_valid_ff))
      else $error("result produced without a decision");

endmodule

[sv/cigar_threshold_filter_unit.sv]
// CIGAR threshold filter. Each req item is one CIGAR operation of an
// alignment record (tlast marks the record's last operation, tuser set means
// the item carries an operation); M, I, D and S lengths add into saturating
// counters and every other type is ignored. For each record exactly one rsp
// item comes out, after its last operation, carrying the keep decision from
// the five thresholds (all ones disables one), reverse mode and keep-unmapped
// mode. The unit takes one item per cycle while the queue is not full:
// operations pass a four-entry queue, then a counter stage that does one add
// per cycle unless a record's last operation waits for the decision stage,
// then a decision stage and an output register. Registers must be written
// only while no record is in flight; the unit itself does not enforce this.
module cigar_threshold_filter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // op_type [7:0], op_length [35:8], record_mapped [36], zero [39:37]
   input  logic [ctf_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // op_present [0]
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // keep_record [0], zero [7:1]
   output logic [ctf_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [ctf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ctf_pkg::THR_BITS-1:0]        csr_wr_data
);

   ctf_pkg::ctf_cfg_type  cfg_ff, cfg_in;
   logic                  push;
   ctf_pkg::op_entry_type push_entry;
   logic                  pop;
   ctf_pkg::op_entry_type pop_entry;
   logic                  not_empty;
   logic                  queue_full;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ctf_pkg::CSR_MATCH_THR:     cfg_in.match_thr          = $signed(csr_wr_data);
            ctf_pkg::CSR_INSERT_THR:    cfg_in.insert_thr         = $signed(csr_wr_data);
            ctf_pkg::CSR_DELETE_THR:    cfg_in.delete_thr         = $signed(csr_wr_data);
            ctf_pkg::CSR_INDEL_THR:     cfg_in.indel_thr          = $signed(csr_wr_data);
            ctf_pkg::CSR_SOFTCLIP_THR:  cfg_in.softclip_thr       = $signed(csr_wr_data);
            ctf_pkg::CSR_REVERSE:       cfg_in.reverse_mode       = csr_wr_data[0];
            ctf_pkg::CSR_KEEP_UNMAPPED: cfg_in.keep_unmapped_mode = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_thr          <= '1;
         cfg_ff.insert_thr         <= '1;
         cfg_ff.delete_thr         <= '1;
         cfg_ff.indel_thr          <= '1;
         cfg_ff.softclip_thr       <= '1;
         cfg_ff.reverse_mode       <= 1'b0;
         cfg_ff.keep_unmapped_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ctf_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   ctf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .not_empty  (not_empty),
      .full       (queue_full)
   );

   ctf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (not_empty),
      .q_entry    (pop_entry),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
